// ===== hw/rtl/ordrl_pkg.sv =====
// Shared types and codes for the ordered request rate limiter.
// No dependencies; imported by every module of the block.
package ordrl_pkg;

	// Request type codes of an input word
	typedef enum logic [1:0] {
		REQ_PLAN_ENTRY = 2'd0,
		REQ_PLAN_EMPTY = 2'd1,
		REQ_DELIVERY   = 2'd2,
		REQ_TICK       = 2'd3
	} req_type_t;

	// Event kinds
	localparam logic EV_ISSUE = 1'b0;
	localparam logic EV_ABORT = 1'b1;

	// Configuration register indexes (byte address bits [3:2])
	localparam logic [1:0] REG_IN_FLIGHT_LIMIT  = 2'd0;
	localparam logic [1:0] REG_WINDOW_STARTS    = 2'd1;
	localparam logic [1:0] REG_WINDOW_PERIOD_MS = 2'd2;

	localparam int unsigned APB_ADDR_BITS = 4;
	localparam int unsigned APB_DATA_BITS = 32;

	localparam logic [4:0]  RST_IN_FLIGHT_LIMIT  = 5'd8;
	localparam logic [4:0]  RST_WINDOW_STARTS    = 5'd0;
	localparam logic [15:0] RST_WINDOW_PERIOD_MS = 16'd1000;

	// Control from the sequencer to the event buffer
	typedef struct packed {
		logic push;   // new event word
		logic flush;  // item finished: release held word as last
		logic kind;
		logic ovf;
	} ev_ctl_t;

endpackage

// ===== hw/rtl/ordrl_ram.sv =====
// Single-port-write, single-port-read memory with registered read data.
// Depends on ordrl_pkg only for the project import convention.
module ordrl_ram
	import ordrl_pkg::*;
#(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/ordrl_evbuf.sv =====
// Event buffer: holds one event word back so the last word of an item can be marked.
// Depends on ordrl_pkg (ev_ctl_t).
module ordrl_evbuf
	import ordrl_pkg::*;
#(
	parameter int unsigned KEY_W = 48,
	parameter int unsigned FC_W  = 5,
	parameter int unsigned PC_W  = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ev_ctl_t          ctl,
	input  logic [KEY_W-1:0] key,
	input  logic [FC_W-1:0]  fcnt,
	input  logic [PC_W-1:0]  pcnt,
	output logic             result_valid,
	output logic             event_kind,
	output logic [KEY_W-1:0] event_key,
	output logic             event_last,
	output logic [FC_W-1:0]  in_flight_count,
	output logic [PC_W-1:0]  pending_count,
	output logic             plan_overflow
);

	logic             hold_v_q;
	logic             hold_kind_q;
	logic [KEY_W-1:0] hold_key_q;
	logic [FC_W-1:0]  hold_fcnt_q;
	logic [PC_W-1:0]  hold_pcnt_q;
	logic             hold_ovf_q;
	logic             out_v_q;
	logic             out_last_q;
	logic             out_kind_q;
	logic [KEY_W-1:0] out_key_q;
	logic [FC_W-1:0]  out_fcnt_q;
	logic [PC_W-1:0]  out_pcnt_q;
	logic             out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			out_v_q <= 1'b0;
			if (ctl.push) begin
				out_v_q    <= hold_v_q;
				out_last_q <= 1'b0;
				hold_v_q   <= 1'b1;
			end else if (ctl.flush) begin
				out_v_q    <= hold_v_q;
				out_last_q <= 1'b1;
				hold_v_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push || ctl.flush) begin
			out_kind_q <= hold_kind_q;
			out_key_q  <= hold_key_q;
			out_fcnt_q <= hold_fcnt_q;
			out_pcnt_q <= hold_pcnt_q;
			out_ovf_q  <= hold_ovf_q;
		end
		if (ctl.push) begin
			hold_kind_q <= ctl.kind;
			hold_key_q  <= key;
			hold_fcnt_q <= fcnt;
			hold_pcnt_q <= pcnt;
			hold_ovf_q  <= ctl.ovf;
		end
	end

	assign result_valid    = out_v_q;
	assign event_kind      = out_kind_q;
	assign event_key       = out_key_q;
	assign event_last      = out_last_q;
	assign in_flight_count = out_fcnt_q;
	assign pending_count   = out_pcnt_q;
	assign plan_overflow   = out_ovf_q;

endmodule

// ===== hw/rtl/ordered_request_rate_limiter_unit.sv =====
// Top level of the ordered request rate limiter: APB registers, sequencer, slot set,
// start-time window and the shared key comparator. Depends on ordrl_pkg, ordrl_ram,
// ordrl_evbuf.
//
// One input word is taken while busy is low; busy then stays high until the last event
// word of the item has been handed to the output register, which strobes it in the
// first cycle after busy falls. Events appear on result_valid for one cycle each
// and cannot be held off. All key searches run one slot or one staged entry per cycle
// through a single key comparator, so timing is set by that comparator. A delivery
// scans the slots for the delivered key and, if it finds it, goes on like a tick, which
// drops expired window starts one at a time and then scans the slots for each pending
// key examined for issue. A plan end first runs the abort pass, each valid slot against
// the staged keys, then rebuilds the pending list, each staged key against the slots,
// and then goes on to the same expiry and issue steps.
module ordered_request_rate_limiter_unit
	import ordrl_pkg::*;
#(
	parameter int unsigned MAX_IN_FLIGHT = 16,
	parameter int unsigned PLAN_DEPTH    = 64,
	parameter int unsigned WINDOW_DEPTH  = 16,
	parameter int unsigned KEY_BITS      = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [APB_ADDR_BITS-1:0]          paddr,
	input  logic [APB_DATA_BITS-1:0]          pwdata,
	output logic [APB_DATA_BITS-1:0]          prdata,
	output logic                              pready,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        req_type,
	input  logic [KEY_BITS-1:0]               tile_key,
	input  logic                              plan_last,
	output logic                              result_valid,
	output logic                              event_kind,
	output logic [KEY_BITS-1:0]               event_key,
	output logic                              event_last,
	output logic [$clog2(MAX_IN_FLIGHT+1)-1:0] in_flight_count,
	output logic [$clog2(PLAN_DEPTH+1)-1:0]   pending_count,
	output logic                              plan_overflow
);

	localparam int unsigned FC_W = $clog2(MAX_IN_FLIGHT + 1);
	localparam int unsigned SL_W = (MAX_IN_FLIGHT > 1) ? $clog2(MAX_IN_FLIGHT) : 1;
	localparam int unsigned PC_W = $clog2(PLAN_DEPTH + 1);
	localparam int unsigned PA_W = $clog2(PLAN_DEPTH);
	localparam int unsigned SF_W = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned WH_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_DLV, S_AB_SLOT, S_AB_CMP, S_AB_KILL, S_RB_RD, S_RB_KEY, S_RB_SCAN,
		S_EXP, S_IS_CHK, S_IS_KEY, S_IS_SCAN, S_IS_GO, S_DONE
	} state_t;

	state_t              state_q;
	logic [4:0]          lim_q;
	logic [4:0]          rate_q;
	logic [15:0]         per_q;
	logic [31:0]         now_q;
	logic [MAX_IN_FLIGHT-1:0] fvalid_q;
	logic [KEY_BITS-1:0] fkeys_q [MAX_IN_FLIGHT];
	logic [FC_W-1:0]     fcnt_q;
	logic [SL_W-1:0]     slot_q;
	logic [PC_W-1:0]     j_q;
	logic [PC_W-1:0]     stg_fill_q;
	logic [PC_W-1:0]     pend_cnt_q;
	logic [PC_W-1:0]     pend_rd_q;
	logic [31:0]         st_q [WINDOW_DEPTH];
	logic [WH_W-1:0]     st_head_q;
	logic [SF_W-1:0]     st_fill_q;
	logic                ovf_q;
	logic                apply_q;
	logic [KEY_BITS-1:0] key_q;

	logic                cfg_wr;
	logic                accept;
	logic [KEY_BITS-1:0] stg_rdata;
	logic [KEY_BITS-1:0] pend_rdata;
	logic [PA_W-1:0]     stg_raddr;
	logic                stg_we;
	logic                pend_we;
	logic [KEY_BITS-1:0] cmp_a;
	logic [KEY_BITS-1:0] slot_key;
	logic                slot_hit;
	logic                slot_last;
	logic                key_eq;
	logic [7:0]          lim_eff;
	logic [7:0]          rate_eff;
	logic                rate_on;
	logic                can_issue;
	logic                win_full;
	logic                expired;
	logic [SL_W-1:0]     free_idx;
	logic [7:0]          tail8;
	logic [WH_W-1:0]     st_tail;
	logic                go_ok;
	logic [PC_W-1:0]     j_inc;
	ev_ctl_t             ev_ctl;
	logic [KEY_BITS-1:0] ev_key;
	logic [FC_W-1:0]     ev_fcnt;
	logic [PC_W-1:0]     ev_pcnt;

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_IN_FLIGHT_LIMIT:  prdata = {27'd0, lim_q};
			REG_WINDOW_STARTS:    prdata = {27'd0, rate_q};
			REG_WINDOW_PERIOD_MS: prdata = {16'd0, per_q};
			default:              prdata = '0;
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Shared key comparator
	assign slot_key  = fkeys_q[slot_q];
	assign cmp_a     = (state_q == S_AB_CMP) ? stg_rdata : key_q;
	assign key_eq    = (cmp_a == slot_key);
	assign slot_hit  = fvalid_q[slot_q] && key_eq;
	assign slot_last = (slot_q == SL_W'(MAX_IN_FLIGHT - 1));
	assign j_inc     = j_q + PC_W'(1);

	// Limits, clamped to the storage depths
	assign lim_eff   = ({3'd0, lim_q} > 8'(MAX_IN_FLIGHT)) ? 8'(MAX_IN_FLIGHT) : {3'd0, lim_q};
	assign rate_eff  = ({3'd0, rate_q} > 8'(WINDOW_DEPTH)) ? 8'(WINDOW_DEPTH) : {3'd0, rate_q};
	assign rate_on   = (rate_q != 5'd0);
	assign can_issue = (pend_cnt_q != '0) && (8'(fcnt_q) < lim_eff);
	assign win_full  = (8'(st_fill_q) >= rate_eff);
	assign go_ok     = !(rate_on && win_full);
	assign expired   = (now_q - st_q[st_head_q]) >= {16'd0, per_q};

	always_comb begin
		tail8 = 8'(st_head_q) + 8'(st_fill_q);
		if (tail8 >= 8'(WINDOW_DEPTH)) begin
			tail8 = tail8 - 8'(WINDOW_DEPTH);
		end
		st_tail = tail8[WH_W-1:0];
	end

	// Lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = MAX_IN_FLIGHT - 1; i >= 0; i--) begin
			if (!fvalid_q[i]) begin
				free_idx = SL_W'(i);
			end
		end
	end

	always_comb begin
		priority case (state_q)
			S_AB_SLOT: stg_raddr = '0;
			S_AB_CMP:  stg_raddr = j_inc[PA_W-1:0];
			default:   stg_raddr = j_q[PA_W-1:0];
		endcase
	end

	assign stg_we  = accept && (req_type == REQ_PLAN_ENTRY) &&
		(stg_fill_q < PC_W'(PLAN_DEPTH));
	assign pend_we = (state_q == S_RB_SCAN) && !slot_hit && slot_last;

	ordrl_ram #(.WIDTH(KEY_BITS), .DEPTH(PLAN_DEPTH)) u_stage (
		.clk   (clk),
		.we    (stg_we),
		.waddr (stg_fill_q[PA_W-1:0]),
		.wdata (tile_key),
		.raddr (stg_raddr),
		.rdata (stg_rdata)
	);

	ordrl_ram #(.WIDTH(KEY_BITS), .DEPTH(PLAN_DEPTH)) u_pend (
		.clk   (clk),
		.we    (pend_we),
		.waddr (pend_cnt_q[PA_W-1:0]),
		.wdata (key_q),
		.raddr (pend_rd_q[PA_W-1:0]),
		.rdata (pend_rdata)
	);

	// Event words
	always_comb begin
		ev_ctl       = '0;
		ev_ctl.ovf   = ovf_q;
		ev_key       = key_q;
		ev_fcnt      = fcnt_q;
		ev_pcnt      = pend_cnt_q;
		if (state_q == S_AB_KILL) begin
			ev_ctl.push = 1'b1;
			ev_ctl.kind = EV_ABORT;
			ev_key      = slot_key;
			ev_fcnt     = fcnt_q - FC_W'(1);
		end else if (state_q == S_IS_GO && go_ok) begin
			ev_ctl.push = 1'b1;
			ev_ctl.kind = EV_ISSUE;
			ev_fcnt     = fcnt_q + FC_W'(1);
			ev_pcnt     = pend_cnt_q - PC_W'(1);
		end
		ev_ctl.flush = (state_q == S_DONE);
	end

	ordrl_evbuf #(.KEY_W(KEY_BITS), .FC_W(FC_W), .PC_W(PC_W)) u_evbuf (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ev_ctl),
		.key             (ev_key),
		.fcnt            (ev_fcnt),
		.pcnt            (ev_pcnt),
		.result_valid    (result_valid),
		.event_kind      (event_kind),
		.event_key       (event_key),
		.event_last      (event_last),
		.in_flight_count (in_flight_count),
		.pending_count   (pending_count),
		.plan_overflow   (plan_overflow)
	);

	// Payload stores, no reset
	always_ff @(posedge clk) begin
		if (state_q == S_IS_GO && go_ok) begin
			fkeys_q[free_idx] <= key_q;
			if (rate_on) begin
				st_q[st_tail] <= now_q;
			end
		end
		priority if (accept) begin
			key_q <= tile_key;
		end else if (state_q == S_RB_KEY) begin
			key_q <= stg_rdata;
		end else if (state_q == S_IS_KEY) begin
			key_q <= pend_rdata;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lim_q      <= RST_IN_FLIGHT_LIMIT;
			rate_q     <= RST_WINDOW_STARTS;
			per_q      <= RST_WINDOW_PERIOD_MS;
			now_q      <= '0;
			fvalid_q   <= '0;
			fcnt_q     <= '0;
			slot_q     <= '0;
			j_q        <= '0;
			stg_fill_q <= '0;
			pend_cnt_q <= '0;
			pend_rd_q  <= '0;
			st_head_q  <= '0;
			st_fill_q  <= '0;
			ovf_q      <= 1'b0;
			apply_q    <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_IN_FLIGHT_LIMIT:  lim_q <= pwdata[4:0];
					REG_WINDOW_STARTS: begin
						rate_q <= pwdata[4:0];
						if (pwdata[4:0] == 5'd0) begin
							st_fill_q <= '0;
							st_head_q <= '0;
						end
					end
					REG_WINDOW_PERIOD_MS: per_q <= pwdata[15:0];
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						apply_q <= 1'b0;
						slot_q  <= '0;
						unique case (req_type)
							REQ_PLAN_ENTRY: begin
								if (stg_fill_q < PC_W'(PLAN_DEPTH)) begin
									stg_fill_q <= stg_fill_q + PC_W'(1);
								end else begin
									ovf_q <= 1'b1;
								end
								if (plan_last) begin
									apply_q <= 1'b1;
									state_q <= S_AB_SLOT;
								end else begin
									state_q <= S_DONE;
								end
							end
							REQ_PLAN_EMPTY: begin
								stg_fill_q <= '0;
								apply_q    <= 1'b1;
								state_q    <= S_AB_SLOT;
							end
							REQ_DELIVERY: state_q <= S_DLV;
							REQ_TICK: begin
								now_q   <= now_q + 32'd1;
								state_q <= S_EXP;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end

				S_DLV: begin
					if (slot_hit) begin
						fvalid_q[slot_q] <= 1'b0;
						fcnt_q           <= fcnt_q - FC_W'(1);
						state_q          <= S_EXP;
					end else if (slot_last) begin
						state_q <= S_DONE;
					end else begin
						slot_q <= slot_q + SL_W'(1);
					end
				end

				// Abort pass: each valid slot against every staged key
				S_AB_SLOT: begin
					j_q <= '0;
					if (fvalid_q[slot_q]) begin
						state_q <= (stg_fill_q == '0) ? S_AB_KILL : S_AB_CMP;
					end else if (slot_last) begin
						j_q     <= '0;
						state_q <= S_RB_RD;
					end else begin
						slot_q <= slot_q + SL_W'(1);
					end
				end

				S_AB_CMP: begin
					if (key_eq) begin
						if (slot_last) begin
							j_q     <= '0;
							state_q <= S_RB_RD;
						end else begin
							slot_q  <= slot_q + SL_W'(1);
							state_q <= S_AB_SLOT;
						end
					end else if (j_inc == stg_fill_q) begin
						state_q <= S_AB_KILL;
					end else begin
						j_q <= j_inc;
					end
				end

				S_AB_KILL: begin
					fvalid_q[slot_q] <= 1'b0;
					fcnt_q           <= fcnt_q - FC_W'(1);
					if (slot_last) begin
						j_q     <= '0;
						state_q <= S_RB_RD;
					end else begin
						slot_q  <= slot_q + SL_W'(1);
						state_q <= S_AB_SLOT;
					end
				end

				// Rebuild pending in plan order, skipping keys in flight
				S_RB_RD: begin
					if (j_q == '0) begin
						pend_cnt_q <= '0;
					end
					if (j_q == stg_fill_q) begin
						stg_fill_q <= '0;
						pend_rd_q  <= '0;
						state_q    <= S_EXP;
					end else begin
						state_q <= S_RB_KEY;
					end
				end

				S_RB_KEY: begin
					slot_q  <= '0;
					state_q <= S_RB_SCAN;
				end

				S_RB_SCAN: begin
					if (slot_hit || slot_last) begin
						if (!slot_hit) begin
							pend_cnt_q <= pend_cnt_q + PC_W'(1);
						end
						j_q     <= j_inc;
						state_q <= S_RB_RD;
					end else begin
						slot_q <= slot_q + SL_W'(1);
					end
				end

				// Drop expired window starts, one per cycle
				S_EXP: begin
					if (rate_on && st_fill_q != '0 && expired) begin
						st_fill_q <= st_fill_q - SF_W'(1);
						if (8'(st_head_q) == 8'(WINDOW_DEPTH - 1)) begin
							st_head_q <= '0;
						end else begin
							st_head_q <= st_head_q + WH_W'(1);
						end
					end else begin
						state_q <= S_IS_CHK;
					end
				end

				S_IS_CHK: state_q <= can_issue ? S_IS_KEY : S_DONE;

				S_IS_KEY: begin
					slot_q  <= '0;
					state_q <= S_IS_SCAN;
				end

				S_IS_SCAN: begin
					if (slot_hit) begin
						pend_rd_q  <= pend_rd_q + PC_W'(1);
						pend_cnt_q <= pend_cnt_q - PC_W'(1);
						state_q    <= S_IS_CHK;
					end else if (slot_last) begin
						state_q <= S_IS_GO;
					end else begin
						slot_q <= slot_q + SL_W'(1);
					end
				end

				S_IS_GO: begin
					if (go_ok) begin
						if (rate_on) begin
							st_fill_q <= st_fill_q + SF_W'(1);
						end
						pend_rd_q          <= pend_rd_q + PC_W'(1);
						pend_cnt_q         <= pend_cnt_q - PC_W'(1);
						fvalid_q[free_idx] <= 1'b1;
						fcnt_q             <= fcnt_q + FC_W'(1);
						state_q            <= S_IS_CHK;
					end else begin
						state_q <= S_DONE;
					end
				end

				S_DONE: begin
					if (apply_q) begin
						ovf_q <= 1'b0;
					end
					state_q <= S_IDLE;
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
